// ===== design/assert_macros.svh =====
// Assertion macros used by the filter core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== design/swmf_pkg.sv =====
// Shared types and constants of the sliding-window median filter.
package swmf_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int WINDOW_DEFAULT = 5;

    // Control bits that the top level hands to each cell.
    typedef struct packed {
        logic gt_lo;       // lower neighbor is greater than the new sample
        logic gt_hi;       // upper neighbor is greater than the new sample
        logic rm_below;    // the oldest entry sits in a lower cell
        logic rm_here;     // the oldest entry sits in this cell
    } t_sel;

    // Status bits that each cell reports.
    typedef struct packed {
        logic gt;          // stored value is greater than the new sample
        logic old;         // stored value is the oldest in the window
    } t_cmp;

endpackage

// ===== design/swmf_cell.sv =====
// One cell of the sorted window chain: holds a value and its age.
module swmf_cell #(
    parameter int WINDOW = swmf_pkg::WINDOW_DEFAULT,
    parameter int INDEX  = 0,
    parameter int AGE_W  = 3
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_shift,
    input  logic signed [swmf_pkg::SAMPLE_W-1:0] i_sample,
    input  swmf_pkg::t_sel                       i_sel,
    input  logic signed [swmf_pkg::SAMPLE_W-1:0] i_lo_value,
    input  logic        [AGE_W-1:0]              i_lo_age,
    input  logic signed [swmf_pkg::SAMPLE_W-1:0] i_hi_value,
    input  logic        [AGE_W-1:0]              i_hi_age,
    output logic signed [swmf_pkg::SAMPLE_W-1:0] o_value,
    output logic        [AGE_W-1:0]              o_age,
    output logic signed [swmf_pkg::SAMPLE_W-1:0] o_next_value,
    output swmf_pkg::t_cmp                       o_cmp
);

    logic signed [swmf_pkg::SAMPLE_W-1:0] r_value, n_value;
    logic        [AGE_W-1:0]              r_age, n_age;
    logic                                 gt_self;
    logic                                 up;
    logic                                 take_le;
    logic                                 prev_le;

    // Compare against the new sample and flag the oldest entry
    assign gt_self   = r_value > i_sample;
    assign o_cmp.gt  = gt_self;
    assign o_cmp.old = (r_age == AGE_W'(WINDOW - 1));

    // Pick the entry for this slot after removing the oldest and inserting the new one
    always_comb begin
        up      = i_sel.rm_below | i_sel.rm_here;
        take_le = up ? !i_sel.gt_hi : !gt_self;
        prev_le = i_sel.rm_below ? !gt_self : !i_sel.gt_lo;
        if (take_le) begin
            n_value = up ? i_hi_value : r_value;
            n_age   = (up ? i_hi_age : r_age) + AGE_W'(1);
        end else if (prev_le) begin
            n_value = i_sample;
            n_age   = '0;
        end else begin
            n_value = i_sel.rm_below ? r_value : i_lo_value;
            n_age   = (i_sel.rm_below ? r_age : i_lo_age) + AGE_W'(1);
        end
    end

    // Hold or advance the cell contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_age   <= AGE_W'(WINDOW - 1 - INDEX);
        end else if (i_shift) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

    assign o_value      = r_value;
    assign o_age        = r_age;
    assign o_next_value = n_value;

endmodule

// ===== design/sliding_window_median_filter_core.sv =====
// The median of a sample is registered at the sample beat and appears on the output in the next cycle.
// Throughput: 1 sample per cycle while the output side takes every result.
// The window is a chain of WINDOW sorted cells, each updated in the same cycle.
// A held result stalls input only while the output register is full and not taken.
// Synchronous active-low reset clears the window to zeros and empties the output.
`include "assert_macros.svh"

module sliding_window_median_filter_core #(
    parameter int WINDOW = swmf_pkg::WINDOW_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [swmf_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [swmf_pkg::SAMPLE_W-1:0] o_median_value
);

    localparam int AGE_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int MID   = WINDOW / 2;

    logic signed [swmf_pkg::SAMPLE_W-1:0] cell_value [WINDOW];
    logic signed [swmf_pkg::SAMPLE_W-1:0] cell_next  [WINDOW];
    logic        [AGE_W-1:0]              cell_age   [WINDOW];
    swmf_pkg::t_cmp                       cell_cmp   [WINDOW];
    swmf_pkg::t_sel                       cell_sel   [WINDOW];
    logic        [WINDOW-1:0]             old_vec;
    logic        [WINDOW-1:0]             rm_below;
    logic                                 shift;
    logic                                 sorted_ok;

    logic                                 r_valid;
    logic signed [swmf_pkg::SAMPLE_W-1:0] r_median;

    assign o_ready = !r_valid || i_ready;
    assign shift   = i_valid && o_ready;

    // Locate the oldest entry relative to each cell
    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            old_vec[i] = cell_cmp[i].old;
        end
        rm_below[0] = 1'b0;
        for (int i = 1; i < WINDOW; i++) begin
            rm_below[i] = rm_below[i-1] | old_vec[i-1];
        end
    end

    // Build the neighbor controls, padding the chain ends
    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            cell_sel[i].gt_lo    = (i == 0) ? 1'b0 : cell_cmp[(i == 0) ? 0 : i-1].gt;
            cell_sel[i].gt_hi    = (i == WINDOW-1) ? 1'b1
                                 : cell_cmp[(i == WINDOW-1) ? i : i+1].gt;
            cell_sel[i].rm_below = rm_below[i];
            cell_sel[i].rm_here  = old_vec[i];
        end
    end

    // Chain of sorted cells
    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        localparam int LO = (g == 0) ? 0 : g - 1;
        localparam int HI = (g == WINDOW - 1) ? g : g + 1;

        swmf_cell #(
            .WINDOW (WINDOW),
            .INDEX  (g),
            .AGE_W  (AGE_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (shift),
            .i_sample     (i_sample),
            .i_sel        (cell_sel[g]),
            .i_lo_value   (cell_value[LO]),
            .i_lo_age     (cell_age[LO]),
            .i_hi_value   (cell_value[HI]),
            .i_hi_age     (cell_age[HI]),
            .o_value      (cell_value[g]),
            .o_age        (cell_age[g]),
            .o_next_value (cell_next[g]),
            .o_cmp        (cell_cmp[g])
        );
    end

    // Capture the middle rank into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (shift) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_median <= cell_next[MID];
        end
    end

    assign o_valid        = r_valid;
    assign o_median_value = r_median;

    // Check that the chain stays in ascending order
    always_comb begin
        sorted_ok = 1'b1;
        for (int i = 0; i < WINDOW - 1; i++) begin
            if (cell_value[i] > cell_value[i+1]) begin
                sorted_ok = 1'b0;
            end
        end
    end

    `ASSERT_ALWAYS(a_one_oldest, i_clk, i_rst_n, $onehot(old_vec), "oldest entry not unique")
    `ASSERT_ALWAYS(a_sorted, i_clk, i_rst_n, sorted_ok, "window chain out of order")
    `ASSERT_NEXT(a_beat_result, i_clk, i_rst_n, shift, o_valid, "sample beat gave no result")

endmodule

// ===== test/tb.sv =====
// Testbench of the sliding-window median filter core, with a rank-select predictor.
module tb;

    localparam int WINDOW    = swmf_pkg::WINDOW_DEFAULT;
    localparam int RANDOM_N  = 1900;
    localparam int LIMIT_T   = 2_000_000;

    // Receiver stall modes
    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;
    localparam int RX_SPARSE  = 3;

    // Random sample kinds
    localparam int KIND_FULL    = 0;
    localparam int KIND_TIES    = 1;
    localparam int KIND_EXTREME = 2;
    localparam int KIND_CLUSTER = 3;

    typedef logic signed [swmf_pkg::SAMPLE_W-1:0] t_sample;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_valid = 1'b0;
    logic    o_ready;
    t_sample i_sample = '0;
    logic    o_valid;
    logic    i_ready = 1'b0;
    t_sample o_median_value;

    t_sample sample_queue[$];
    t_sample median_expected[$];
    t_sample window_hist[WINDOW];
    int      errors     = 0;
    int      burst_left = 1;
    int      gap_left   = 0;
    int      rx_mode    = RX_ALWAYS;
    int      rx_left    = 0;
    int      rx_phase   = 0;
    logic [15:0] rx_mask = 16'hFFFF;

    sliding_window_median_filter_core #(.WINDOW(WINDOW)) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_median_value (o_median_value)
    );

    // Clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Shift a sample into the window and queue the value of rank WINDOW/2
    task automatic predict_median(input t_sample s);
        t_sample sorted[WINDOW];
        t_sample v;
        int      j;
        for (int i = 0; i < WINDOW - 1; i++) begin
            window_hist[i] = window_hist[i + 1];
        end
        window_hist[WINDOW - 1] = s;
        sorted = window_hist;
        // insertion sort, ascending
        for (int i = 1; i < WINDOW; i++) begin
            v = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j] > v) begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = v;
        end
        median_expected.push_back(sorted[WINDOW / 2]);
    endtask

    function automatic t_sample random_sample(input int kind);
        t_sample s;
        case (kind)
            KIND_FULL: begin
                s = t_sample'($urandom);
            end
            KIND_TIES: begin
                s = t_sample'($urandom_range(0, 6)) - t_sample'(3);
            end
            KIND_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: s = 16'sh8000;
                    1: s = 16'sh7FFF;
                    2: s = '0;
                    default: s = -16'sd1;
                endcase
            end
            default: begin
                s = t_sample'($urandom_range(0, 40)) - t_sample'(20) + 16'sd1000;
            end
        endcase
        return s;
    endfunction

    // Sender: accept beats, predict, then advance in bursts with gaps
    always @(posedge i_clk) begin : sender
        logic took;
        took = i_valid && o_ready;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (took) begin
                predict_median(i_sample);
            end
            if (!i_valid || took) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (sample_queue.size() > 0) begin
                    i_sample <= sample_queue.pop_front();
                    i_valid  <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall on a mode that is drawn anew each time its run ends
    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (rx_left <= 0) begin
                rx_mode = $urandom_range(RX_ALWAYS, RX_SPARSE);
                rx_left = $urandom_range(20, 300);
                rx_mask = 16'($urandom) | 16'h0001;
            end
            rx_left--;
            rx_phase = (rx_phase + 1) % 16;
            case (rx_mode)
                RX_ALWAYS:  i_ready <= 1'b1;
                RX_RANDOM:  i_ready <= 1'($urandom_range(0, 1));
                RX_PATTERN: i_ready <= rx_mask[rx_phase];
                default:    i_ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // Monitor: compare each result beat with the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_sample want;
        if (i_rst_n && o_valid && i_ready) begin
            if (median_expected.size() == 0) begin
                $display("%0t: unexpected median beat, expected none, actual %0d",
                         $time, o_median_value);
                errors++;
            end else begin
                want = median_expected.pop_front();
                if (o_median_value !== want) begin
                    $display("%0t: median_value mismatch, expected %0d, actual %0d",
                             $time, want, o_median_value);
                    errors++;
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin : stimulus
        t_sample directed[];
        int kind;
        int run;
        directed = '{
            16'sd7, -16'sd5, 16'sd100,                  // start-up: reset zeros take part
            16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
            16'sh8000, 16'sh8000, 16'sh8000,
            16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
            16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5,     // all equal
            -16'sd1, 16'sd1, 16'sd0,
            16'sd1, 16'sd2, 16'sd3, 16'sd4
        };
        for (int i = 0; i < WINDOW; i++) begin
            window_hist[i] = '0;
        end
        foreach (directed[i]) begin
            sample_queue.push_back(directed[i]);
        end
        // random runs of one kind each
        while (sample_queue.size() < directed.size() + RANDOM_N) begin
            kind = $urandom_range(KIND_FULL, KIND_CLUSTER);
            run  = $urandom_range(1, 30);
            for (int i = 0; i < run; i++) begin
                sample_queue.push_back(random_sample(kind));
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // check for the drained state away from the active edge
        while (sample_queue.size() > 0 || i_valid || median_expected.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (5) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Hang guard
    initial begin : watchdog
        #(LIMIT_T);
        $display("tb: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/swmf_pkg.sv
design/swmf_cell.sv
design/sliding_window_median_filter_core.sv
test/tb.sv
